@@ rtl/mlcm_pkg.sv @@
// Shared types and constants for the multichannel color-table merge block.
package mlcm_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 40;  // channel, level, red, green, blue + pad
  localparam int OUT_TDATA_W = 32;  // red, green, blue, alpha

  localparam int CHAN_W  = 3;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 11;
  localparam int COUNT_W = 4;

  localparam logic [SUM_W-1:0]   SUM_LIMIT   = 11'h7FF;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 4'hF;

  // restoring divide: one quotient bit per step
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = 4;

  // tuser codes
  localparam logic CMD_TABLE_WRITE = 1'b0;
  localparam logic CMD_SAMPLE      = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BUILD_ALPHA       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MODE          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LUMINANCE_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_RGB_MASK   = 3'd5;

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd10;

  // luminance weights, out of 256
  localparam int LUM_W    = 19;
  localparam int LUM_RED   = 77;
  localparam int LUM_GREEN = 151;
  localparam int LUM_BLUE  = 28;

  typedef struct packed {
    logic tbl_wr;    // write table entry from the input transfer
    logic capture;   // latch sample fields, launch table read
    logic acc;       // accumulate the captured sample
    logic div_step;  // one quotient bit of the average
    logic load_out;  // move result to output register, clear sums
  } cmd_t;

  typedef struct packed {
    logic last;        // captured sample closes the voxel
    logic div_needed;  // alpha is the average of counted samples
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

@@ rtl/mlcm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module mlcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/mlcm_ctrl.sv @@
// Controller state machine for the color-table merge.
module mlcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tuser,
  output logic                s_tready,
  input  mlcm_pkg::sts_t      sts,
  output mlcm_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [mlcm_pkg::STEP_W-1:0] LAST_STEP =
    mlcm_pkg::STEP_W'(mlcm_pkg::DIV_STEPS - 1);

  logic [1:0]                  state, state_next;
  logic [mlcm_pkg::STEP_W-1:0] step_cnt, step_cnt_next;

  always_comb begin
    state_next    = state;
    step_cnt_next = '0;
    cmd           = '0;
    s_tready      = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == mlcm_pkg::CMD_SAMPLE) begin
            cmd.capture = 1'b1;
            state_next  = S_ACC;
          end else begin
            cmd.tbl_wr = 1'b1;
          end
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last) begin
          state_next = sts.div_needed ? S_DIV : S_FIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == LAST_STEP) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule

@@ rtl/mlcm_datapath.sv @@
// Datapath: color tables, accumulators, average divider, output register.
module mlcm_datapath #(
  parameter int MAX_CHANNELS  = 8,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mlcm_pkg::cmd_t                       cmd,
  output mlcm_pkg::sts_t                       sts,
  input  logic                                 cfg_we,
  input  logic [mlcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mlcm_pkg::CFG_W-1:0]           cfg_data,
  input  logic [mlcm_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [mlcm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int DEPTH = MAX_CHANNELS * TABLE_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = mlcm_pkg::PIX_W;
  localparam int SW    = mlcm_pkg::SUM_W;
  localparam int CW    = mlcm_pkg::COUNT_W;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [PW-1:0] v);
    logic [SW:0] s;
    s = {1'b0, a} + (SW+1)'(v);
    return s[SW] ? mlcm_pkg::SUM_LIMIT : s[SW-1:0];
  endfunction

  function automatic logic [PW-1:0] clamp255(input logic [SW-1:0] v);
    return (v > SW'(255)) ? 8'hFF : v[PW-1:0];
  endfunction

  // input fields
  logic [mlcm_pkg::CHAN_W-1:0] in_chan;
  logic [PW-1:0]               in_level, in_red, in_green, in_blue;
  assign in_chan  = s_tdata[2:0];
  assign in_level = s_tdata[10:3];
  assign in_red   = s_tdata[18:11];
  assign in_green = s_tdata[26:19];
  assign in_blue  = s_tdata[34:27];

  // configuration
  logic          build_alpha, max_mode, average_mode, luminance_mode;
  logic [PW-1:0] average_threshold, direct_rgb_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      build_alpha       <= 1'b0;
      max_mode          <= 1'b0;
      average_mode      <= 1'b0;
      luminance_mode    <= 1'b0;
      average_threshold <= mlcm_pkg::THRESHOLD_RESET;
      direct_rgb_mask   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mlcm_pkg::REG_BUILD_ALPHA:       build_alpha       <= cfg_data[0];
        mlcm_pkg::REG_MAX_MODE:          max_mode          <= cfg_data[0];
        mlcm_pkg::REG_AVERAGE_MODE:      average_mode      <= cfg_data[0];
        mlcm_pkg::REG_LUMINANCE_MODE:    luminance_mode    <= cfg_data[0];
        mlcm_pkg::REG_AVERAGE_THRESHOLD: average_threshold <= cfg_data;
        mlcm_pkg::REG_DIRECT_RGB_MASK:   direct_rgb_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic avg_on;
  assign avg_on = average_mode | ~max_mode;

  // table addressing
  logic          chan_ok, level_ok;
  logic [PW-1:0] rd_idx;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [23:0]   tbl_rd;

  assign chan_ok  = 32'(in_chan) < MAX_CHANNELS;
  assign level_ok = 32'(in_level) < TABLE_ENTRIES;
  assign rd_idx   = level_ok ? in_level : PW'(TABLE_ENTRIES - 1);
  assign wr_addr  = AW'(32'(in_chan) * 32'(TABLE_ENTRIES) + 32'(in_level));
  assign rd_addr  = AW'(32'(in_chan) * 32'(TABLE_ENTRIES) + 32'(rd_idx));

  mlcm_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_tables (
    .clk    (clk),
    .wr_en  (cmd.tbl_wr && chan_ok && level_ok),
    .wr_addr(wr_addr),
    .wr_data({in_red, in_green, in_blue}),
    .rd_en  (cmd.capture),
    .rd_addr(rd_addr),
    .rd_data(tbl_rd)
  );

  // captured sample
  logic [mlcm_pkg::CHAN_W-1:0] cap_chan;
  logic [PW-1:0]               cap_level, cap_red, cap_green, cap_blue;
  logic                        cap_last, cap_chan_ok;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_chan    <= in_chan;
      cap_level   <= in_level;
      cap_red     <= in_red;
      cap_green   <= in_green;
      cap_blue    <= in_blue;
      cap_last    <= s_tlast;
      cap_chan_ok <= chan_ok;
    end
  end

  // accumulate
  logic [SW-1:0] red_sum, green_sum, blue_sum, alpha_accum;
  logic [CW-1:0] above_count;
  logic [SW-1:0] alpha_accum_next;
  logic [CW-1:0] above_count_next;
  logic [PW-1:0] add_r, add_g, add_b;
  logic          direct;

  assign direct = direct_rgb_mask[cap_chan];

  always_comb begin
    if (direct) begin
      add_r = cap_red;
      add_g = cap_green;
      add_b = cap_blue;
    end else if (cap_chan_ok) begin
      add_r = tbl_rd[23:16];
      add_g = tbl_rd[15:8];
      add_b = tbl_rd[7:0];
    end else begin
      add_r = '0;
      add_g = '0;
      add_b = '0;
    end
  end

  always_comb begin
    alpha_accum_next = alpha_accum;
    above_count_next = above_count;
    if (build_alpha) begin
      if (max_mode) begin
        if (SW'(cap_level) > alpha_accum) begin
          alpha_accum_next = SW'(cap_level);
        end
      end else if (avg_on && cap_level > average_threshold) begin
        alpha_accum_next = sat_add(alpha_accum, cap_level);
        if (above_count != mlcm_pkg::COUNT_LIMIT) begin
          above_count_next = above_count + 1'b1;
        end
      end
    end
  end

  // average divider: the quotient shifts in one bit per div_step command
  logic [SW-1:0] quot;
  logic [CW-1:0] rem;
  logic [CW:0]   rem_sh;
  logic          rem_ge;

  assign rem_sh = {rem, quot[SW-1]};
  assign rem_ge = rem_sh >= {1'b0, above_count};

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      quot <= alpha_accum_next;
      rem  <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[SW-2:0], rem_ge};
      rem  <= rem_ge ? CW'(rem_sh - {1'b0, above_count}) : rem_sh[CW-1:0];
    end
  end

  // final alpha selection
  logic                      div_sel;
  logic [mlcm_pkg::LUM_W-1:0] lum;
  logic [PW-1:0]             alpha;

  assign div_sel = avg_on && !max_mode && (above_count != '0);
  assign lum = mlcm_pkg::LUM_W'(red_sum)   * mlcm_pkg::LUM_W'(mlcm_pkg::LUM_RED)
             + mlcm_pkg::LUM_W'(green_sum) * mlcm_pkg::LUM_W'(mlcm_pkg::LUM_GREEN)
             + mlcm_pkg::LUM_W'(blue_sum)  * mlcm_pkg::LUM_W'(mlcm_pkg::LUM_BLUE);

  always_comb begin
    if (!build_alpha) begin
      alpha = '0;
    end else if (div_sel) begin
      alpha = clamp255(quot);
    end else if (luminance_mode) begin
      alpha = clamp255(lum[mlcm_pkg::LUM_W-1:8]);
    end else begin
      alpha = clamp255(alpha_accum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      red_sum     <= '0;
      green_sum   <= '0;
      blue_sum    <= '0;
      alpha_accum <= '0;
      above_count <= '0;
    end else if (cmd.acc) begin
      red_sum     <= sat_add(red_sum, add_r);
      green_sum   <= sat_add(green_sum, add_g);
      blue_sum    <= sat_add(blue_sum, add_b);
      alpha_accum <= alpha_accum_next;
      above_count <= above_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {alpha, clamp255(blue_sum), clamp255(green_sum), clamp255(red_sum)};
    end
  end

  assign sts.last       = cap_last;
  assign sts.div_needed = build_alpha && avg_on && !max_mode && (above_count_next != '0);
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

@@ rtl/multichannel_lut_color_merge.sv @@
// Table write: taken while idle. Channel sample: table read, then accumulate.
// Last sample of a voxel: the bit-serial average divider runs when alpha is the
// average of counted samples, then the result enters the free output register.
// A finished result waits in the output register while the next voxel streams in.
// Reset clears the controller, sums, counts and output valid, and sets the
// registers to their defaults; color table contents are kept, not cleared.
module multichannel_lut_color_merge #(
  parameter int MAX_CHANNELS  = 8,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mlcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlcm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // channel[2:0], level[10:3], red_in[18:11], green_in[26:19], blue_in[34:27]
  input  logic [mlcm_pkg::IN_TDATA_W-1:0]     s_tdata,
  // command: table write or sample
  input  logic                                s_tuser,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
  output logic [mlcm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  mlcm_pkg::cmd_t cmd;
  mlcm_pkg::sts_t sts;

  mlcm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tuser (s_tuser),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  mlcm_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  a_sample_accumulates: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == mlcm_pkg::CMD_SAMPLE) |=> cmd.acc)
    else $error("accepted sample was not accumulated");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transfer");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("loaded result not presented");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (cmd.acc || cmd.div_step) |-> !s_tready)
    else $error("input ready while a sample is in work");
`endif

endmodule
